@@ hdl/spi_pkg.sv @@
// shared types and constants for the segment pair intersection core
// no dependencies; imported by every module of the block
`timescale 1ns / 1ps
`default_nettype none

package spi_pkg;

	// fixed field widths of the stream words
	localparam int IN_BITS     = 12;
	localparam int IN_FIELDS   = 8;
	localparam int LIMIT_BITS  = 13;
	localparam int OUT_BITS    = 16;
	localparam int IN_WORD     = 96;
	localparam int OUT_WORD    = 40;

	// parameter defaults
	localparam int COORD_BITS_DEF = 12;
	localparam int FRAC_BITS_DEF  = 4;

	localparam logic [LIMIT_BITS-1:0] LIMIT_RESET = 13'd10;

	// result status codes
	typedef enum logic [1:0] {
		ST_FAR   = 2'd0,
		ST_DEGEN = 2'd1,
		ST_MISS  = 2'd2,
		ST_CROSS = 2'd3
	} status_t;

endpackage

`default_nettype wire

@@ hdl/spi_front.sv @@
// front stages s1..s3: endpoint distances, parametric terms, classification
// depends on spi_pkg
`timescale 1ns / 1ps
`default_nettype none

module spi_front #(
	parameter int COORD_BITS = spi_pkg::COORD_BITS_DEF
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              in_valid,
	output logic                                   in_ready,
	input  wire logic [spi_pkg::IN_WORD-1:0]       in_data,
	input  wire logic [spi_pkg::LIMIT_BITS-1:0]    near_limit,
	output logic                                   out_valid,
	input  wire logic                              out_ready,
	output spi_pkg::status_t                       out_status,
	output logic [2*COORD_BITS:0]                  out_den,
	output logic [2*COORD_BITS:0]                  out_num,
	output logic [COORD_BITS-1:0]                  out_x1,
	output logic [COORD_BITS-1:0]                  out_y1,
	output logic [COORD_BITS-1:0]                  out_x2,
	output logic [COORD_BITS-1:0]                  out_y2
);
	import spi_pkg::*;

	localparam int C    = COORD_BITS;
	localparam int SQW  = 2 * C;
	localparam int DSW  = 2 * C + 1;
	localparam int PRW  = 2 * C + 2;
	localparam int TW   = 2 * C + 3;
	localparam int LSQW = 2 * LIMIT_BITS;
	localparam int CMPW = (DSW > LSQW) ? DSW : LSQW;

	logic v_s1, v_s2, v_s3;
	logic en1, en2, en3;

	// stall chain
	assign en3      = !v_s3 || out_ready;
	assign en2      = !v_s2 || en3;
	assign en1      = !v_s1 || en2;
	assign in_ready = en1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			if (en1) v_s1 <= in_valid;
			if (en2) v_s2 <= v_s1;
			if (en3) v_s3 <= v_s2;
		end
	end

	// coordinate unpacking, low COORD_BITS of each field
	logic        [C-1:0] crd   [IN_FIELDS];
	logic signed [C:0]   cs    [IN_FIELDS];
	always_comb begin
		logic [C+IN_BITS-1:0] ext;
		for (int i = 0; i < IN_FIELDS; i++) begin
			ext    = {{C{1'b0}}, in_data[IN_BITS*i +: IN_BITS]};
			crd[i] = ext[C-1:0];
			cs[i]  = $signed({1'b0, ext[C-1:0]});
		end
	end

	// s1: endpoint squares and cross products
	logic signed [C:0]   dd   [8];
	logic signed [C:0]   ta, tb, tc, te, tf, tg;
	logic [SQW-1:0]      sq_c [8];
	logic signed [PRW-1:0] pr_c [6];
	always_comb begin
		logic signed [PRW-1:0] sqp;
		dd[0] = cs[0] - cs[4];
		dd[1] = cs[1] - cs[5];
		dd[2] = cs[0] - cs[6];
		dd[3] = cs[1] - cs[7];
		dd[4] = cs[2] - cs[4];
		dd[5] = cs[3] - cs[5];
		dd[6] = cs[2] - cs[6];
		dd[7] = cs[3] - cs[7];
		for (int i = 0; i < 8; i++) begin
			sqp     = dd[i] * dd[i];
			sq_c[i] = sqp[SQW-1:0];
		end
		ta = cs[6] - cs[4];
		tb = cs[3] - cs[1];
		tc = cs[7] - cs[5];
		te = cs[2] - cs[0];
		tf = cs[5] - cs[1];
		tg = cs[4] - cs[0];
		pr_c[0] = ta * tb;
		pr_c[1] = tc * te;
		pr_c[2] = ta * tf;
		pr_c[3] = tg * tc;
		pr_c[4] = tf * te;
		pr_c[5] = tg * tb;
	end

	logic [SQW-1:0]        sq_s1  [8];
	logic signed [PRW-1:0] pr_s1  [6];
	logic [LSQW-1:0]       lsq_s1;
	logic [C-1:0]          pt_s1  [4];

	always_ff @(posedge clk) begin
		if (en1) begin
			sq_s1  <= sq_c;
			pr_s1  <= pr_c;
			lsq_s1 <= near_limit * near_limit;
			pt_s1[0] <= crd[0];
			pt_s1[1] <= crd[1];
			pt_s1[2] <= crd[2];
			pt_s1[3] <= crd[3];
		end
	end

	// s2: distance sums, first min level, den and numerators
	logic [DSW-1:0]      ds_c [4];
	logic signed [TW-1:0] den_c, na_c, nb_c;
	always_comb begin
		for (int i = 0; i < 4; i++) begin
			ds_c[i] = {1'b0, sq_s1[2*i]} + {1'b0, sq_s1[2*i+1]};
		end
		den_c = {pr_s1[0][PRW-1], pr_s1[0]} - {pr_s1[1][PRW-1], pr_s1[1]};
		na_c  = {pr_s1[2][PRW-1], pr_s1[2]} - {pr_s1[3][PRW-1], pr_s1[3]};
		nb_c  = {pr_s1[4][PRW-1], pr_s1[4]} - {pr_s1[5][PRW-1], pr_s1[5]};
	end

	logic [DSW-1:0]       m01_s2, m23_s2;
	logic signed [TW-1:0] den_s2, na_s2, nb_s2;
	logic [LSQW-1:0]      lsq_s2;
	logic [C-1:0]         pt_s2 [4];

	always_ff @(posedge clk) begin
		if (en2) begin
			m01_s2 <= (ds_c[0] < ds_c[1]) ? ds_c[0] : ds_c[1];
			m23_s2 <= (ds_c[2] < ds_c[3]) ? ds_c[2] : ds_c[3];
			den_s2 <= den_c;
			na_s2  <= na_c;
			nb_s2  <= nb_c;
			lsq_s2 <= lsq_s1;
			pt_s2  <= pt_s1;
		end
	end

	// s3: proximity gate, range tests, sign fix of den and na
	status_t              st_c;
	logic [DSW-1:0]       dabs_c, nabs_c;
	always_comb begin
		logic [DSW-1:0]       dmin;
		logic [CMPW+DSW-1:0]  dext;
		logic [CMPW+LSQW-1:0] lext;
		logic                 near, zero, ua_ok, ub_ok;
		logic signed [TW-1:0] dneg, nneg;
		dmin = (m01_s2 < m23_s2) ? m01_s2 : m23_s2;
		dext = {{CMPW{1'b0}}, dmin};
		lext = {{CMPW{1'b0}}, lsq_s2};
		near = dext[CMPW-1:0] < lext[CMPW-1:0];
		zero = (den_s2 == '0) || (na_s2 == '0) || (nb_s2 == '0);
		if (den_s2 > 0) begin
			ua_ok = (na_s2 >= 0) && (na_s2 <= den_s2);
			ub_ok = (nb_s2 >= 0) && (nb_s2 <= den_s2);
		end else begin
			ua_ok = (na_s2 <= 0) && (na_s2 >= den_s2);
			ub_ok = (nb_s2 <= 0) && (nb_s2 >= den_s2);
		end
		if (!near)
			st_c = ST_FAR;
		else if (zero)
			st_c = ST_DEGEN;
		else if (!(ua_ok && ub_ok))
			st_c = ST_MISS;
		else
			st_c = ST_CROSS;
		dneg = -den_s2;
		nneg = -na_s2;
		if (den_s2 < 0) begin
			dabs_c = dneg[DSW-1:0];
			nabs_c = nneg[DSW-1:0];
		end else begin
			dabs_c = den_s2[DSW-1:0];
			nabs_c = na_s2[DSW-1:0];
		end
	end

	logic [C-1:0] pt_s3 [4];
	always_ff @(posedge clk) begin
		if (en3) begin
			out_status <= st_c;
			out_den    <= dabs_c;
			out_num    <= nabs_c;
			pt_s3      <= pt_s2;
		end
	end

	assign out_valid = v_s3;
	assign out_x1    = pt_s3[0];
	assign out_y1    = pt_s3[1];
	assign out_x2    = pt_s3[2];
	assign out_y2    = pt_s3[3];

endmodule

`default_nettype wire

@@ hdl/spi_lerp.sv @@
// stages s4..s5: weighted endpoint sums that feed the crossing divider
// depends on spi_pkg
`timescale 1ns / 1ps
`default_nettype none

module spi_lerp #(
	parameter int COORD_BITS = spi_pkg::COORD_BITS_DEF,
	parameter int FRAC_BITS  = spi_pkg::FRAC_BITS_DEF
) (
	input  wire logic                                   clk,
	input  wire logic                                   arst_n,
	input  wire logic                                   in_valid,
	output logic                                        in_ready,
	input  wire spi_pkg::status_t                       in_status,
	input  wire logic [2*COORD_BITS:0]                  in_den,
	input  wire logic [2*COORD_BITS:0]                  in_num,
	input  wire logic [COORD_BITS-1:0]                  in_x1,
	input  wire logic [COORD_BITS-1:0]                  in_y1,
	input  wire logic [COORD_BITS-1:0]                  in_x2,
	input  wire logic [COORD_BITS-1:0]                  in_y2,
	output logic                                        out_valid,
	input  wire logic                                   out_ready,
	output spi_pkg::status_t                            out_status,
	output logic [2*COORD_BITS:0]                       out_den,
	output logic [3*COORD_BITS+FRAC_BITS:0]             out_numx,
	output logic [3*COORD_BITS+FRAC_BITS:0]             out_numy
);
	import spi_pkg::*;

	localparam int C  = COORD_BITS;
	localparam int DW = 2 * C + 1;
	localparam int PW = 3 * C + 1;
	localparam int NW = PW + FRAC_BITS;

	logic v_s4, v_s5;
	logic en4, en5;

	assign en5      = !v_s5 || out_ready;
	assign en4      = !v_s4 || en5;
	assign in_ready = en4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else begin
			if (en4) v_s4 <= in_valid;
			if (en5) v_s5 <= v_s4;
		end
	end

	// s4: p*(d-n) and q*n for both axes
	logic [DW-1:0] dmn_c;
	assign dmn_c = in_den - in_num;

	logic [PW-1:0] px_s4, qx_s4, py_s4, qy_s4;
	logic [DW-1:0] d_s4;
	status_t       st_s4;

	always_ff @(posedge clk) begin
		if (en4) begin
			px_s4 <= in_x1 * dmn_c;
			qx_s4 <= in_x2 * in_num;
			py_s4 <= in_y1 * dmn_c;
			qy_s4 <= in_y2 * in_num;
			d_s4  <= in_den;
			st_s4 <= in_status;
		end
	end

	// s5: scaled dividends; non-crossing words divide zero by one
	logic [PW-1:0] sx_c, sy_c;
	assign sx_c = px_s4 + qx_s4;
	assign sy_c = py_s4 + qy_s4;

	always_ff @(posedge clk) begin
		if (en5) begin
			out_status <= st_s4;
			if (st_s4 == ST_CROSS) begin
				out_numx <= NW'(sx_c) << FRAC_BITS;
				out_numy <= NW'(sy_c) << FRAC_BITS;
				out_den  <= d_s4;
			end else begin
				out_numx <= '0;
				out_numy <= '0;
				out_den  <= DW'(1);
			end
		end
	end

	assign out_valid = v_s5;

endmodule

`default_nettype wire

@@ hdl/spi_div.sv @@
// pipelined restoring divider, one quotient bit per stage, x and y lanes
// depends on spi_pkg
`timescale 1ns / 1ps
`default_nettype none

module spi_div #(
	parameter int COORD_BITS = spi_pkg::COORD_BITS_DEF,
	parameter int FRAC_BITS  = spi_pkg::FRAC_BITS_DEF
) (
	input  wire logic                                   clk,
	input  wire logic                                   arst_n,
	input  wire logic                                   in_valid,
	output logic                                        in_ready,
	input  wire spi_pkg::status_t                       in_status,
	input  wire logic [2*COORD_BITS:0]                  in_den,
	input  wire logic [3*COORD_BITS+FRAC_BITS:0]        in_numx,
	input  wire logic [3*COORD_BITS+FRAC_BITS:0]        in_numy,
	output logic                                        out_valid,
	input  wire logic                                   out_ready,
	output spi_pkg::status_t                            out_status,
	output logic [COORD_BITS+FRAC_BITS-1:0]             out_qx,
	output logic [COORD_BITS+FRAC_BITS-1:0]             out_qy
);
	import spi_pkg::*;

	localparam int C  = COORD_BITS;
	localparam int DW = 2 * C + 1;
	localparam int QW = C + FRAC_BITS;

	// index 0 is the incoming word, index k the register of divide stage k
	logic [QW:0]   v_s;
	logic [QW+1:1] en;
	logic [DW-1:0] remx_s [QW+1];
	logic [DW-1:0] remy_s [QW+1];
	logic [QW-1:0] lox_s  [QW+1];
	logic [QW-1:0] loy_s  [QW+1];
	logic [QW-1:0] qx_s   [QW+1];
	logic [QW-1:0] qy_s   [QW+1];
	logic [DW-1:0] d_s    [QW+1];
	status_t       st_s   [QW+1];

	// quotient fits in QW bits, so the top dividend bits start as remainder
	assign v_s[0]    = in_valid;
	assign remx_s[0] = in_numx[DW+QW-1:QW];
	assign remy_s[0] = in_numy[DW+QW-1:QW];
	assign lox_s[0]  = in_numx[QW-1:0];
	assign loy_s[0]  = in_numy[QW-1:0];
	assign qx_s[0]   = '0;
	assign qy_s[0]   = '0;
	assign d_s[0]    = in_den;
	assign st_s[0]   = in_status;

	assign en[QW+1]  = out_ready;
	assign in_ready  = en[1];

	for (genvar k = 1; k <= QW; k++) begin : g_stage
		logic [DW:0] tx, ty;
		logic        gx, gy;
		logic [DW:0] rx, ry;

		assign en[k] = !v_s[k] || en[k+1];

		// trial subtract on the shifted remainder
		assign tx = {remx_s[k-1], lox_s[k-1][QW-1]};
		assign ty = {remy_s[k-1], loy_s[k-1][QW-1]};
		assign gx = tx >= {1'b0, d_s[k-1]};
		assign gy = ty >= {1'b0, d_s[k-1]};
		assign rx = gx ? (tx - {1'b0, d_s[k-1]}) : tx;
		assign ry = gy ? (ty - {1'b0, d_s[k-1]}) : ty;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[k] <= 1'b0;
			end else if (en[k]) begin
				v_s[k] <= v_s[k-1];
			end
		end

		always_ff @(posedge clk) begin
			if (en[k]) begin
				remx_s[k] <= rx[DW-1:0];
				remy_s[k] <= ry[DW-1:0];
				lox_s[k]  <= {lox_s[k-1][QW-2:0], 1'b0};
				loy_s[k]  <= {loy_s[k-1][QW-2:0], 1'b0};
				qx_s[k]   <= {qx_s[k-1][QW-2:0], gx};
				qy_s[k]   <= {qy_s[k-1][QW-2:0], gy};
				d_s[k]    <= d_s[k-1];
				st_s[k]   <= st_s[k-1];
			end
		end
	end

	assign out_valid  = v_s[QW];
	assign out_status = st_s[QW];
	assign out_qx     = qx_s[QW];
	assign out_qy     = qy_s[QW];

endmodule

`default_nettype wire

@@ hdl/segment_pair_intersection_core.sv @@
// top level of the segment pair intersection core
// depends on spi_pkg, spi_front, spi_lerp, spi_div
//
// usage:
//   s_tvalid/s_tready/s_tdata carry one segment pair per word, eight 12 bit
//   coordinates: first start x,y, first end x,y, second start x,y, second
//   end x,y. m_tvalid/m_tready/m_tdata return exactly one result word per
//   pair, in order: status, crossing x and y in 1/2^FRAC_BITS pixel.
//   cfg_valid/cfg_ready/cfg_data write the 13 bit near limit; write it only
//   while no pair is in flight. cfg_ready is always high.
// timing:
//   one pair per cycle sustained while m_tready stays high. the pipe has
//   three front stages, two weighting stages and one divide stage per
//   quotient bit of the crossing divider.
// reset:
//   arst_n clears all valid bits and sets the near limit to 10.
// stalls:
//   every stage holds its word while the next one is full and stalled, so
//   bubbles close up; s_tready drops only when the whole pipe is full and
//   m_tready is low. nothing is lost or repeated.
`timescale 1ns / 1ps
`default_nettype none

module segment_pair_intersection_core #(
	parameter int COORD_BITS = spi_pkg::COORD_BITS_DEF,
	parameter int FRAC_BITS  = spi_pkg::FRAC_BITS_DEF
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              cfg_valid,
	output logic                                   cfg_ready,
	input  wire logic [spi_pkg::LIMIT_BITS-1:0]    cfg_data,
	input  wire logic                              s_tvalid,
	output logic                                   s_tready,
	// first_start_x, first_start_y, first_end_x, first_end_y,
	// second_start_x, second_start_y, second_end_x, second_end_y
	input  wire logic [spi_pkg::IN_WORD-1:0]       s_tdata,
	output logic                                   m_tvalid,
	input  wire logic                              m_tready,
	// pair_status[1:0], cross_x[17:2], cross_y[33:18], zero fill
	output logic [spi_pkg::OUT_WORD-1:0]           m_tdata
);
	import spi_pkg::*;

	localparam int C  = COORD_BITS;
	localparam int DW = 2 * C + 1;
	localparam int NW = 3 * C + 1 + FRAC_BITS;
	localparam int QW = C + FRAC_BITS;

	// near limit register
	logic [LIMIT_BITS-1:0] near_limit_q;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			near_limit_q <= LIMIT_RESET;
		end else if (cfg_valid && cfg_ready) begin
			near_limit_q <= cfg_data;
		end
	end

	// front to weighting
	logic          f_valid, f_ready;
	status_t       f_status;
	logic [DW-1:0] f_den, f_num;
	logic [C-1:0]  f_x1, f_y1, f_x2, f_y2;

	spi_front #(.COORD_BITS(COORD_BITS)) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (s_tvalid),
		.in_ready   (s_tready),
		.in_data    (s_tdata),
		.near_limit (near_limit_q),
		.out_valid  (f_valid),
		.out_ready  (f_ready),
		.out_status (f_status),
		.out_den    (f_den),
		.out_num    (f_num),
		.out_x1     (f_x1),
		.out_y1     (f_y1),
		.out_x2     (f_x2),
		.out_y2     (f_y2)
	);

	// weighting to divider
	logic          l_valid, l_ready;
	status_t       l_status;
	logic [DW-1:0] l_den;
	logic [NW-1:0] l_numx, l_numy;

	spi_lerp #(.COORD_BITS(COORD_BITS), .FRAC_BITS(FRAC_BITS)) u_lerp (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (f_valid),
		.in_ready   (f_ready),
		.in_status  (f_status),
		.in_den     (f_den),
		.in_num     (f_num),
		.in_x1      (f_x1),
		.in_y1      (f_y1),
		.in_x2      (f_x2),
		.in_y2      (f_y2),
		.out_valid  (l_valid),
		.out_ready  (l_ready),
		.out_status (l_status),
		.out_den    (l_den),
		.out_numx   (l_numx),
		.out_numy   (l_numy)
	);

	status_t       d_status;
	logic [QW-1:0] d_qx, d_qy;

	spi_div #(.COORD_BITS(COORD_BITS), .FRAC_BITS(FRAC_BITS)) u_div (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (l_valid),
		.in_ready   (l_ready),
		.in_status  (l_status),
		.in_den     (l_den),
		.in_numx    (l_numx),
		.in_numy    (l_numy),
		.out_valid  (m_tvalid),
		.out_ready  (m_tready),
		.out_status (d_status),
		.out_qx     (d_qx),
		.out_qy     (d_qy)
	);

	// result word, crossing fields kept to 16 bits
	logic [QW+OUT_BITS-1:0] qx_ext, qy_ext;
	assign qx_ext  = {{OUT_BITS{1'b0}}, d_qx};
	assign qy_ext  = {{OUT_BITS{1'b0}}, d_qy};
	assign m_tdata = {6'b0, qy_ext[OUT_BITS-1:0], qx_ext[OUT_BITS-1:0], d_status};

endmodule

`default_nettype wire

@@ hdl/spi_chk.sv @@
// port-level checker for the segment pair intersection core, with its bind
// depends on spi_pkg and segment_pair_intersection_core
`timescale 1ns / 1ps
`default_nettype none

module spi_chk (
	input wire logic                           clk,
	input wire logic                           arst_n,
	input wire logic                           s_tvalid,
	input wire logic                           s_tready,
	input wire logic                           m_tvalid,
	input wire logic                           m_tready,
	input wire logic [spi_pkg::OUT_WORD-1:0]   m_tdata
);
	import spi_pkg::*;

	// stalled result word holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result word changed under stall");

	// crossing fields are zero unless the pair crosses
	a_zero_fields: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tdata[1:0] != ST_CROSS) |-> m_tdata[33:2] == '0)
		else $error("nonzero crossing on a non-crossing result");

	// input is refused only when the output is full and stalled
	a_backpressure: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> m_tvalid && !m_tready)
		else $error("input stalled while output free");

	// fill bits above the fields stay zero
	a_fill: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[39:34] == '0)
		else $error("fill bits set in result word");

endmodule

bind segment_pair_intersection_core spi_chk u_spi_chk (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);

`default_nettype wire

@@ tb/tb_segment_pair_intersection_core.sv @@
// self-checking testbench for segment_pair_intersection_core
// depends on spi_pkg and the core; predicts each result word and compares in order
`timescale 1ns / 1ps

module tb_segment_pair_intersection_core;
	import spi_pkg::*;

	typedef struct {
		logic [IN_BITS-1:0] x1, y1, x2, y2, x3, y3, x4, y4;
	} seg_pair_t;

	typedef struct {
		status_t       status;
		logic [15:0]   cx;
		logic [15:0]   cy;
	} cross_res_t;

	localparam int MAX_CYCLES = 400000;
	localparam int LATENCY    = 21;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [LIMIT_BITS-1:0] cfg_data = '0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [IN_WORD-1:0] s_tdata = '0;
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [OUT_WORD-1:0] m_tdata;

	seg_pair_t  pair_q[$];
	cross_res_t cross_q[$];
	logic [LIMIT_BITS-1:0] limit_model = LIMIT_RESET;
	int errors = 0;
	int n_checked = 0;
	int n_cross = 0;
	int n_cfg = 0;
	int cycles = 0;
	int gap_left = 0;
	int stall_left = 0;
	bit calm = 1'b0;
	bit send_busy = 1'b0;

	segment_pair_intersection_core u_dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
	);

	always #5 clk = ~clk;

	// squared endpoint distance
	function automatic longint sqd(longint ax, longint ay, longint bx, longint by);
		return (ax - bx) * (ax - bx) + (ay - by) * (ay - by);
	endfunction

	// fixed point interpolation, d > 0 and 0 <= n <= d
	function automatic logic [15:0] interp_fix(longint p, longint q, longint n, longint d);
		longint num;
		num = (p * (d - n) + q * n) << FRAC_BITS_DEF;
		return 16'(num / d);
	endfunction

	function automatic bit unit_param(longint n, longint d);
		if (d > 0) begin
			return n >= 0 && n <= d;
		end
		return n <= 0 && n >= d;
	endfunction

	function automatic cross_res_t predict_cross(seg_pair_t p, logic [LIMIT_BITS-1:0] lim);
		cross_res_t r;
		longint x1, y1, x2, y2, x3, y3, x4, y4, dmin, den, na, nb, l;
		x1 = p.x1; y1 = p.y1; x2 = p.x2; y2 = p.y2;
		x3 = p.x3; y3 = p.y3; x4 = p.x4; y4 = p.y4;
		l = lim;
		r.status = ST_FAR; r.cx = '0; r.cy = '0;
		dmin = sqd(x1, y1, x3, y3);
		if (sqd(x1, y1, x4, y4) < dmin) dmin = sqd(x1, y1, x4, y4);
		if (sqd(x2, y2, x3, y3) < dmin) dmin = sqd(x2, y2, x3, y3);
		if (sqd(x2, y2, x4, y4) < dmin) dmin = sqd(x2, y2, x4, y4);
		if (!(dmin < l * l)) return r;
		den = (x4 - x3) * (y2 - y1) - (y4 - y3) * (x2 - x1);
		na  = (x4 - x3) * (y3 - y1) - (x3 - x1) * (y4 - y3);
		nb  = (y3 - y1) * (x2 - x1) - (x3 - x1) * (y2 - y1);
		if (den == 0 || na == 0 || nb == 0) begin
			r.status = ST_DEGEN;
			return r;
		end
		if (!unit_param(na, den) || !unit_param(nb, den)) begin
			r.status = ST_MISS;
			return r;
		end
		if (den < 0) begin
			den = -den;
			na = -na;
		end
		r.status = ST_CROSS;
		r.cx = interp_fix(x1, x2, na, den);
		r.cy = interp_fix(y1, y2, na, den);
		return r;
	endfunction

	function automatic seg_pair_t mk_pair(int a, int b, int c, int d, int e, int f, int g, int h);
		seg_pair_t p;
		p.x1 = a; p.y1 = b; p.x2 = c; p.y2 = d;
		p.x3 = e; p.y3 = f; p.x4 = g; p.y4 = h;
		return p;
	endfunction

	// append a pair to the pending queue
	function automatic void queue_pair(seg_pair_t p);
		pair_q = {pair_q, p};
	endfunction

	function automatic int near_coord(int c, int span);
		int v;
		v = c + $urandom_range(2 * span) - span;
		if (v < 0) v = 0;
		if (v > 4095) v = 4095;
		return v;
	endfunction

	// random pair, mostly two segments with nearby endpoints so the gate opens
	function automatic seg_pair_t rand_pair();
		int cx, cy, span, sel;
		sel = $urandom_range(9);
		if (sel == 0) begin
			return mk_pair($urandom_range(4095), $urandom_range(4095), $urandom_range(4095),
				$urandom_range(4095), $urandom_range(4095), $urandom_range(4095),
				$urandom_range(4095), $urandom_range(4095));
		end
		span = (sel < 4) ? 6 : ((sel < 8) ? 60 : 2000);
		cx = $urandom_range(4095);
		cy = $urandom_range(4095);
		return mk_pair(near_coord(cx, span), near_coord(cy, span), near_coord(cx, span),
			near_coord(cy, span), near_coord(cx, span), near_coord(cy, span),
			near_coord(cx, span), near_coord(cy, span));
	endfunction

	function automatic logic [IN_WORD-1:0] pack_pair(seg_pair_t p);
		return {p.y4, p.x4, p.y3, p.x3, p.y2, p.x2, p.y1, p.x1};
	endfunction

	// word driver and m_tready stall source, falling edge
	always @(negedge clk) begin
		if (arst_n) begin
			if (send_busy) begin
				// hold the word
			end else if (gap_left > 0) begin
				gap_left <= gap_left - 1;
				s_tvalid <= 1'b0;
			end else if (!calm && s_tvalid && $urandom_range(7) == 0) begin
				gap_left <= $urandom_range(3);
				s_tvalid <= 1'b0;
			end else if (pair_q.size() > 0) begin
				s_tdata <= pack_pair(pair_q[0]);
				cross_q = {cross_q, predict_cross(pair_q[0], limit_model)};
				void'(pair_q.pop_front());
				s_tvalid <= 1'b1;
			end else begin
				s_tvalid <= 1'b0;
			end
			if (stall_left > 0) begin
				stall_left <= stall_left - 1;
				m_tready <= 1'b0;
			end else if (!calm && $urandom_range(7) == 0) begin
				stall_left <= $urandom_range(3);
				m_tready <= 1'b0;
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		send_busy <= s_tvalid && !s_tready;
	end

	// result monitor, rising edge
	always @(posedge clk) begin
		cross_res_t exp_r;
		logic [1:0] got_st;
		logic [15:0] got_x, got_y;
		cycles <= cycles + 1;
		if (arst_n && m_tvalid && m_tready) begin
			got_st = m_tdata[1:0];
			got_x = m_tdata[17:2];
			got_y = m_tdata[33:18];
			if (cross_q.size() == 0) begin
				$display("%0t: unexpected word, actual status %0d x %0d y %0d",
					$time, got_st, got_x, got_y);
				errors = errors + 1;
			end else begin
				exp_r = cross_q.pop_front();
				n_checked <= n_checked + 1;
				if (exp_r.status == ST_CROSS) n_cross <= n_cross + 1;
				if (got_st != exp_r.status) begin
					$display("%0t: status expected %0d actual %0d", $time, exp_r.status, got_st);
					errors = errors + 1;
				end
				if (got_x != exp_r.cx) begin
					$display("%0t: cross_x expected %0d actual %0d", $time, exp_r.cx, got_x);
					errors = errors + 1;
				end
				if (got_y != exp_r.cy) begin
					$display("%0t: cross_y expected %0d actual %0d", $time, exp_r.cy, got_y);
					errors = errors + 1;
				end
			end
		end
	end

	// timeout guard
	always @(posedge clk) begin
		if (cycles > MAX_CYCLES) begin
			$display("segment_pair_intersection_core verification failed");
			$finish;
		end
	end

	// wait until everything sent has come back, then let the pipe drain
	task automatic drain();
		while (pair_q.size() > 0 || s_tvalid || cross_q.size() > 0) @(posedge clk);
		repeat (LATENCY + 4) @(posedge clk);
	endtask

	task automatic write_limit(logic [LIMIT_BITS-1:0] v);
		@(negedge clk);
		cfg_data <= v;
		cfg_valid <= 1'b1;
		do @(posedge clk); while (!cfg_ready);
		limit_model = v;
		n_cfg++;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic random_batch(int n);
		for (int i = 0; i < n; i++) queue_pair(rand_pair());
	endtask

	initial begin
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed: reset limit 10, each status and the corner values
		queue_pair(mk_pair(0, 0, 8, 8, 0, 8, 8, 0));         // cross at (4,4)
		queue_pair(mk_pair(0, 0, 0, 0, 0, 0, 0, 0));         // all zero, degenerate
		queue_pair(mk_pair(0, 0, 5, 0, 0, 1, 5, 1));         // parallel
		queue_pair(mk_pair(0, 0, 5, 5, 0, 0, 5, 5));         // identical
		queue_pair(mk_pair(0, 0, 6, 0, 0, 0, 0, 6));         // touch at start point
		queue_pair(mk_pair(0, 0, 3, 0, 5, 1, 5, 4));         // lines meet off segments
		queue_pair(mk_pair(0, 0, 9, 0, 20, 20, 30, 30));     // too far
		queue_pair(mk_pair(0, 0, 7, 3, 1, 5, 6, 0));         // fractional crossing
		queue_pair(mk_pair(4095, 4095, 4088, 4090, 4088, 4095, 4095, 4089));
		queue_pair(mk_pair(4095, 0, 4090, 6, 4090, 0, 4095, 5));
		queue_pair(mk_pair(0, 4095, 6, 4089, 0, 4089, 6, 4095));
		drain();
		write_limit('0);                                     // limit zero
		queue_pair(mk_pair(0, 0, 8, 8, 0, 8, 8, 0));
		queue_pair(mk_pair(5, 5, 5, 5, 5, 5, 5, 5));
		drain();
		write_limit(13'h1FFF);                               // above range
		queue_pair(mk_pair(0, 0, 4095, 4095, 0, 4095, 4095, 0));
		queue_pair(mk_pair(4095, 0, 0, 4095, 0, 0, 4095, 4095));
		queue_pair(mk_pair(0, 0, 4095, 1, 4095, 0, 0, 4095));
		queue_pair(mk_pair(2730, 1365, 1365, 2730, 2730, 2730, 1365, 1365));
		drain();

		// random phases over several limits
		write_limit(13'd4096);
		random_batch(120);
		drain();
		write_limit(13'd1);
		random_batch(60);
		drain();
		write_limit(13'd8);
		random_batch(120);
		drain();
		write_limit(13'($urandom_range(8191)));
		random_batch(100);
		drain();
		write_limit(13'd200);
		random_batch(120);
		drain();
		calm = 1'b1;
		random_batch(80);
		drain();

		$display("checked %0d result words, %0d crossings, %0d limit writes",
			n_checked, n_cross, n_cfg);
		if (errors == 0) begin
			$display("segment_pair_intersection_core verification clean");
		end else begin
			$display("segment_pair_intersection_core verification failed");
		end
		$finish;
	end

endmodule
